// ===== rtl/core/pct_pkg.sv =====
// ============================================================================
// pct_pkg - shared types, codes and helpers of the pausable countdown timer
// Holds the transaction structs, the command, phase, flag and status codes,
// the configuration indexes and the millisecond-to-microsecond clamp.
// ============================================================================
package pct_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME_MS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME_US  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_US    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CD_MS   = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_MIN_TIME_MS = 16'd10;
    localparam logic [22:0] RST_MAX_TIME_MS = 23'd4200000;
    localparam logic [31:0] RST_MAX_TIME_US = 32'd4200000000;
    localparam logic [15:0] RST_MARGIN_US   = 16'd500;
    localparam logic [31:0] RST_COUNTDOWN_US = 32'd0;

    // Item kinds
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Commands
    localparam logic [2:0] CMD_RESET  = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_PAUSE  = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_SET_CD = 3'd4;

    // Phases
    localparam logic [1:0] PH_RESET = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Pending flag bit positions
    localparam int unsigned F_START  = 0;
    localparam int unsigned F_STOP   = 1;
    localparam int unsigned F_BPAUSE = 2;
    localparam int unsigned F_EPAUSE = 3;
    localparam int unsigned F_CALC   = 4;
    localparam int unsigned F_W      = 5;

    // Status codes
    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_BAD_ARG        = 4'd1;
    localparam logic [3:0] ST_NOT_COMPLETE   = 4'd2;
    localparam logic [3:0] ST_NOT_ACTIVE     = 4'd3;
    localparam logic [3:0] ST_ALREADY_PAUSED = 4'd4;
    localparam logic [3:0] ST_CD_IGNORED     = 4'd5;
    localparam logic [3:0] ST_BELOW_MIN      = 4'd6;
    localparam logic [3:0] ST_ABOVE_MAX      = 4'd7;
    localparam logic [3:0] ST_ZERO           = 4'd8;
    localparam logic [3:0] ST_PAUSE_BUDGET   = 4'd9;

    localparam logic [32:0] US_PER_MS = 33'd1000;

    typedef struct packed {
        logic        op;
        logic [2:0]  command;
        logic        with_countdown;
        logic [31:0] countdown_ms;
        logic [31:0] now_us;
    } t_item;

    typedef struct packed {
        logic        running;
        logic [1:0]  phase;
        logic        phase_changed;
        logic [31:0] elapsed_us;
        logic [31:0] remaining_us;
        logic [31:0] start_us;
        logic [31:0] stop_us;
        logic [31:0] paused_us;
        logic [3:0]  status;
    } t_result;

    typedef struct packed {
        logic [31:0] us;
        logic [3:0]  code;
    } t_conv;

    // Clamp a millisecond request and scale it to microseconds, saturating.
    // A value that passes the max check fits in 23 bits.
    function automatic t_conv scale_countdown(input logic [31:0] ms,
                                              input logic [15:0] min_ms,
                                              input logic [22:0] max_ms);
        t_conv       c;
        logic [22:0] sel;
        logic [32:0] prod;
        c.code = ST_OK;
        if ((ms != 32'd0) && (ms < {16'd0, min_ms})) begin
            c.code = ST_BELOW_MIN;
            sel = {7'd0, min_ms};
        end else if (ms > {9'd0, max_ms}) begin
            c.code = ST_ABOVE_MAX;
            sel = max_ms;
        end else begin
            if (ms == 32'd0) begin
                c.code = ST_ZERO;
            end
            sel = ms[22:0];
        end
        prod = {10'd0, sel} * US_PER_MS;
        c.us = prod[32] ? '1 : prod[31:0];
        return c;
    endfunction

endpackage

// ===== rtl/core/pausable_countdown_timer.sv =====
// ============================================================================
// pausable_countdown_timer - countdown timer with start, pause and stop
// Commands queue pending work; tick transactions carry the time and apply it.
// ============================================================================
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ----------------------------
//  input     in         i_in_valid / o_in_ready      op, command, countdown, now
//  result    out        o_out_valid / i_out_ready    status and timer snapshot
//  config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
//  Every transaction, command or tick, passes the core once and gives
//  one result; a new one is accepted each cycle while the result channel is
//  not stalled, and each passes the input register, then the result register.
//  Throughput is set by the state update in the core.
//  Reset is synchronous, active low; it clears all timer state and loads the
//  configuration defaults. A stalled result holds the core; the input
//  register then fills and o_in_ready drops.
//
module pausable_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [2:0]  i_command,
    input  logic        i_with_countdown,
    input  logic [31:0] i_countdown_ms,
    input  logic [31:0] i_now_us,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_running,
    output logic [1:0]  o_phase,
    output logic        o_phase_changed,
    output logic [31:0] o_elapsed_us,
    output logic [31:0] o_remaining_us,
    output logic [31:0] o_start_us,
    output logic [31:0] o_stop_us,
    output logic [31:0] o_paused_us,
    output logic [3:0]  o_status
);
    import pct_pkg::*;

    t_item   in_item;
    t_item   core_item;
    logic    core_valid;
    logic    core_take;
    logic    res_ready;
    t_result core_res;
    t_result out_res;

    // pack the input fields into one transaction
    assign in_item.op             = i_op;
    assign in_item.command        = i_command;
    assign in_item.with_countdown = i_with_countdown;
    assign in_item.countdown_ms   = i_countdown_ms;
    assign in_item.now_us         = i_now_us;

    // hold the incoming transaction until the core takes it
    pct_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (core_take),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    // advance the timer state by one transaction whenever the result slot frees
    pct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (core_valid),
        .i_item      (core_item),
        .i_res_ready (res_ready),
        .o_take      (core_take),
        .o_res       (core_res)
    );

    // hold the result until the consumer takes it
    pct_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (core_take),
        .i_res        (core_res),
        .o_load_ready (res_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_res        (out_res)
    );

    // unpack the result fields
    assign o_running       = out_res.running;
    assign o_phase         = out_res.phase;
    assign o_phase_changed = out_res.phase_changed;
    assign o_elapsed_us    = out_res.elapsed_us;
    assign o_remaining_us  = out_res.remaining_us;
    assign o_start_us      = out_res.start_us;
    assign o_stop_us       = out_res.stop_us;
    assign o_paused_us     = out_res.paused_us;
    assign o_status        = out_res.status;

endmodule

// ===== rtl/core/pct_in_stage.sv =====
// ============================================================================
// pct_in_stage - input register
// Captures one input transaction and holds it until the core takes it.
// ============================================================================
module pct_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pct_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output pct_pkg::t_item o_item
);
    import pct_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/core/pct_core.sv =====
// ============================================================================
// pct_core - timer state and per-transaction update
// Holds configuration and timer state, queues commands and runs ticks.
// ============================================================================
module pct_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pct_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    input  pct_pkg::t_item                     i_item,
    input  logic                               i_res_ready,
    output logic                               o_take,
    output pct_pkg::t_result                   o_res
);
    import pct_pkg::*;

    // configuration
    logic [15:0] r_min_ms;
    logic [22:0] r_max_ms;
    logic [31:0] r_max_us;
    logic [15:0] r_margin_us;

    // timer state
    logic           r_active, n_active;
    logic [1:0]     r_req_phase, n_req_phase;
    logic [1:0]     r_rep_phase, n_rep_phase;
    logic           r_change, n_change;
    logic [F_W-1:0] r_pend, n_pend;
    logic [31:0]    r_cd_us, n_cd_us;
    logic [31:0]    r_ts_start, n_ts_start;
    logic [31:0]    r_ts_stop, n_ts_stop;
    logic [31:0]    r_ts_pause, n_ts_pause;
    logic [31:0]    r_ts_pbegin, n_ts_pbegin;
    logic [31:0]    r_elapsed, n_elapsed;
    logic [31:0]    r_remaining, n_remaining;
    logic [3:0]     status;

    logic        pend_active;
    t_conv       cmd_conv;
    t_conv       cfg_conv;
    logic [31:0] cur_pause;
    logic [31:0] used_pause;
    logic [31:0] room;
    logic [31:0] elapsed;
    logic [32:0] elapsed_margin;

    assign o_take = i_valid && i_res_ready;

    assign pend_active = !r_pend[F_STOP] && (r_pend[F_START] || r_active);
    assign cmd_conv = scale_countdown(i_item.countdown_ms, r_min_ms, r_max_ms);
    assign cfg_conv = scale_countdown({9'd0, i_cfg_data[22:0]}, r_min_ms, r_max_ms);

    always_comb begin
        n_active    = r_active;
        n_req_phase = r_req_phase;
        n_rep_phase = r_rep_phase;
        n_change    = r_change;
        n_pend      = r_pend;
        n_cd_us     = r_cd_us;
        n_ts_start  = r_ts_start;
        n_ts_stop   = r_ts_stop;
        n_ts_pause  = r_ts_pause;
        n_ts_pbegin = r_ts_pbegin;
        n_elapsed   = r_elapsed;
        n_remaining = r_remaining;
        status      = ST_OK;
        cur_pause      = '0;
        used_pause     = '0;
        room           = '0;
        elapsed        = '0;
        elapsed_margin = '0;

        if (i_item.op == OP_COMMAND) begin
            if (i_item.command == CMD_SET_CD) begin
                if (!pend_active) begin
                    n_cd_us = cmd_conv.us;
                    status  = cmd_conv.code;
                end else begin
                    status = ST_NOT_COMPLETE;
                end
            end else if (i_item.command > CMD_SET_CD) begin
                status = ST_BAD_ARG;
            end else begin
                // take the carried countdown where the command allows it
                if (i_item.with_countdown) begin
                    case (i_item.command)
                        CMD_START: begin
                            if (!pend_active) begin
                                n_cd_us = cmd_conv.us;
                                status  = cmd_conv.code;
                            end else if (r_req_phase == PH_PAUSE) begin
                                status = ST_CD_IGNORED;
                            end
                        end
                        CMD_RESET: begin
                            n_cd_us = cmd_conv.us;
                            status  = cmd_conv.code;
                        end
                        default: begin
                            status = ST_CD_IGNORED;
                        end
                    endcase
                end
                // queue the command as pending flags
                case (i_item.command)
                    CMD_START: begin
                        if (!pend_active) begin
                            n_pend[F_START]  = 1'b1;
                            n_pend[F_EPAUSE] = 1'b0;
                            n_pend[F_STOP]   = 1'b0;
                            n_req_phase      = PH_START;
                        end else if (r_req_phase == PH_PAUSE) begin
                            n_pend[F_EPAUSE] = 1'b1;
                            n_pend[F_CALC]   = 1'b1;
                            n_req_phase      = PH_START;
                        end else begin
                            status = ST_NOT_COMPLETE;
                        end
                    end
                    CMD_RESET: begin
                        n_pend[F_START]  = 1'b1;
                        n_pend[F_BPAUSE] = 1'b0;
                        n_pend[F_EPAUSE] = 1'b0;
                        n_pend[F_STOP]   = 1'b0;
                        n_req_phase      = PH_RESET;
                    end
                    CMD_PAUSE: begin
                        if (pend_active) begin
                            if (r_req_phase == PH_START || r_req_phase == PH_RESET) begin
                                n_pend[F_BPAUSE] = 1'b1;
                                n_pend[F_CALC]   = 1'b0;
                                n_req_phase      = PH_PAUSE;
                            end else begin
                                status = ST_ALREADY_PAUSED;
                            end
                        end else begin
                            status = ST_NOT_ACTIVE;
                        end
                    end
                    default: begin
                        if (pend_active) begin
                            n_pend[F_STOP] = 1'b1;
                            n_pend[F_CALC] = 1'b1;
                            if (r_req_phase == PH_PAUSE) begin
                                n_pend[F_EPAUSE] = 1'b1;
                            end
                            n_req_phase = PH_STOP;
                        end else begin
                            status = ST_NOT_ACTIVE;
                        end
                    end
                endcase
            end
        end else begin
            n_change    = 1'b0;
            n_rep_phase = r_req_phase;
            // start or reset
            if (n_pend[F_START]) begin
                n_pend[F_START] = 1'b0;
                if (r_cd_us != 32'd0) begin
                    n_pend[F_CALC] = !n_pend[F_BPAUSE];
                end else begin
                    n_pend[F_CALC] = 1'b0;
                    n_pend[F_STOP] = 1'b1;
                end
                n_change    = 1'b1;
                n_active    = 1'b1;
                n_ts_start  = i_item.now_us;
                n_remaining = r_cd_us;
                n_elapsed   = '0;
                n_ts_pause  = '0;
                n_ts_pbegin = '0;
                n_ts_stop   = '0;
            end
            // pause begin
            if (n_pend[F_BPAUSE]) begin
                n_pend[F_BPAUSE] = 1'b0;
                n_change    = 1'b1;
                n_ts_pbegin = i_item.now_us;
            end
            // pause budget guard
            cur_pause  = i_item.now_us - n_ts_pbegin;
            used_pause = cur_pause + n_ts_pause;
            room       = r_max_us - r_cd_us;
            if (n_active && (n_rep_phase == PH_PAUSE) && !n_pend[F_EPAUSE]) begin
                if (used_pause >= room) begin
                    status = ST_PAUSE_BUDGET;
                    n_pend[F_EPAUSE] = 1'b1;
                    n_pend[F_CALC]   = 1'b1;
                    n_pend[F_STOP]   = 1'b1;
                end
            end
            // pause end: fold the pause into the total
            if (n_pend[F_EPAUSE]) begin
                n_pend[F_EPAUSE] = 1'b0;
                n_change   = 1'b1;
                n_ts_pause = used_pause;
            end
            // elapsed and remaining
            elapsed        = i_item.now_us - n_ts_pause - n_ts_start;
            elapsed_margin = {1'b0, elapsed} + {17'd0, r_margin_us};
            if (n_pend[F_CALC]) begin
                if (elapsed_margin >= {1'b0, r_cd_us}) begin
                    n_remaining    = '0;
                    n_elapsed      = r_cd_us;
                    n_pend[F_CALC] = 1'b0;
                    n_pend[F_STOP] = 1'b1;
                end else begin
                    n_remaining = r_cd_us - elapsed;
                    n_elapsed   = elapsed;
                end
            end
            // stop
            if (n_pend[F_STOP]) begin
                n_pend      = '0;
                n_change    = 1'b1;
                n_active    = 1'b0;
                n_rep_phase = PH_STOP;
                n_req_phase = PH_STOP;
                n_ts_stop   = i_item.now_us;
            end
        end
    end

    assign o_res.running       = n_active;
    assign o_res.phase         = n_rep_phase;
    assign o_res.phase_changed = n_change;
    assign o_res.elapsed_us    = n_elapsed;
    assign o_res.remaining_us  = n_remaining;
    assign o_res.start_us      = n_ts_start;
    assign o_res.stop_us       = n_ts_stop;
    assign o_res.paused_us     = n_ts_pause;
    assign o_res.status        = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ms    <= RST_MIN_TIME_MS;
            r_max_ms    <= RST_MAX_TIME_MS;
            r_max_us    <= RST_MAX_TIME_US;
            r_margin_us <= RST_MARGIN_US;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_TIME_MS: r_min_ms    <= i_cfg_data[15:0];
                CFG_MAX_TIME_MS: r_max_ms    <= i_cfg_data[22:0];
                CFG_MAX_TIME_US: r_max_us    <= i_cfg_data[31:0];
                CFG_MARGIN_US:   r_margin_us <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_req_phase <= PH_STOP;
            r_rep_phase <= PH_STOP;
            r_change    <= 1'b0;
            r_pend      <= '0;
            r_cd_us     <= RST_COUNTDOWN_US;
            r_ts_start  <= '0;
            r_ts_stop   <= '0;
            r_ts_pause  <= '0;
            r_ts_pbegin <= '0;
            r_elapsed   <= '0;
            r_remaining <= '0;
        end else begin
            if (o_take) begin
                r_active    <= n_active;
                r_req_phase <= n_req_phase;
                r_rep_phase <= n_rep_phase;
                r_change    <= n_change;
                r_pend      <= n_pend;
                r_ts_start  <= n_ts_start;
                r_ts_stop   <= n_ts_stop;
                r_ts_pause  <= n_ts_pause;
                r_ts_pbegin <= n_ts_pbegin;
                r_elapsed   <= n_elapsed;
                r_remaining <= n_remaining;
            end
            // a countdown load from configuration uses the current limits
            if (i_cfg_we && (i_cfg_index == CFG_INIT_CD_MS)) begin
                r_cd_us <= cfg_conv.us;
            end else if (o_take) begin
                r_cd_us <= n_cd_us;
            end
        end
    end

`ifndef SYNTHESIS
    // queued work other than a start exists only for a live or starting run
    a_pend_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend[F_BPAUSE] || r_pend[F_EPAUSE] || r_pend[F_CALC] || r_pend[F_STOP])
        |-> (r_active || r_pend[F_START]))
        else $error("pending work without an active or starting run");

    // a tick consumes start and pause-begin requests
    a_tick_consumes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (i_item.op == OP_TICK)) |=> (!r_pend[F_START] && !r_pend[F_BPAUSE]))
        else $error("tick left start or pause-begin pending");

    // after a tick the reported phase is stop exactly when the run is complete
    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (i_item.op == OP_TICK)) |=> (r_active == (r_rep_phase != PH_STOP)))
        else $error("reported phase disagrees with running flag");
`endif

endmodule

// ===== rtl/core/pct_out_stage.sv =====
// ============================================================================
// pct_out_stage - result register
// Holds one result transaction until the consumer takes it.
// ============================================================================
module pct_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pct_pkg::t_result i_res,
    output logic             o_load_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output pct_pkg::t_result o_res
);
    import pct_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_load_ready = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// pausable_countdown_timer testbench
// Drives command and tick transactions through the valid/ready input channel.
// Each transaction is predicted by a cycle-free copy of the timer state in this
// module. Every result is checked field by field in order of arrival. The run
// has a directed part and a long random part, with register settings changed
// between phases and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import pct_pkg::*;

    // Run limits: the timeout covers the slowest legal run several times over
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned REPORT_CAP     = 100;
    localparam int unsigned HOLD_OFF_LEN   = 300;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 250;
    // Command codes the block rejects as bad arguments
    localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = 1'b0;
    logic [2:0]  i_command = '0;
    logic        i_with_countdown = 1'b0;
    logic [31:0] i_countdown_ms = '0;
    logic [31:0] i_now_us = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_running;
    logic [1:0]  o_phase;
    logic        o_phase_changed;
    logic [31:0] o_elapsed_us;
    logic [31:0] o_remaining_us;
    logic [31:0] o_start_us;
    logic [31:0] o_stop_us;
    logic [31:0] o_paused_us;
    logic [3:0]  o_status;

    pausable_countdown_timer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_command        (i_command),
        .i_with_countdown (i_with_countdown),
        .i_countdown_ms   (i_countdown_ms),
        .i_now_us         (i_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_running        (o_running),
        .o_phase          (o_phase),
        .o_phase_changed  (o_phase_changed),
        .o_elapsed_us     (o_elapsed_us),
        .o_remaining_us   (o_remaining_us),
        .o_start_us       (o_start_us),
        .o_stop_us        (o_stop_us),
        .o_paused_us      (o_paused_us),
        .o_status         (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predicted timer: register copy and timer state
    // ------------------------------------------------------------------------
    logic [15:0]    cfg_min_ms;
    logic [22:0]    cfg_max_ms;
    logic [31:0]    cfg_budget_us;
    logic [15:0]    cfg_margin_us;

    logic           tmr_active;
    logic [1:0]     tmr_req_phase;
    logic [1:0]     tmr_shown_phase;
    logic           tmr_changed;
    logic [F_W-1:0] tmr_pending;
    logic [31:0]    tmr_countdown_us;
    logic [31:0]    tmr_elapsed_us;
    logic [31:0]    tmr_remaining_us;
    logic [31:0]    ts_start;
    logic [31:0]    ts_stop;
    logic [31:0]    ts_paused;
    logic [31:0]    ts_pause_begin;
    logic [3:0]     item_code;

    t_result        expected_snapshots[$];

    // Bookkeeping shared by the stimulus, the result monitor and the summary
    logic           idling_on = 1'b1;
    int unsigned    hold_request = 0;
    logic [31:0]    wall_us = '0;
    int unsigned    mismatch_count = 0;
    int unsigned    items_sent = 0;
    int unsigned    ticks_sent = 0;
    int unsigned    results_checked = 0;
    int unsigned    config_writes = 0;
    int unsigned    timer_stops = 0;
    int unsigned    status_seen[16];
    int unsigned    cycle_count = 0;

    // Clamp a millisecond request into range and scale it, saturating at 32 bits.
    // The minimum check goes first, so it wins when min is above max.
    function automatic logic [31:0] clamp_countdown(input logic [31:0] ms);
        logic [63:0] scaled;
        if (ms != 32'd0 && ms < {16'd0, cfg_min_ms}) begin
            item_code = ST_BELOW_MIN;
            scaled = 64'(cfg_min_ms) * 64'd1000;
        end else if (ms > {9'd0, cfg_max_ms}) begin
            item_code = ST_ABOVE_MAX;
            scaled = 64'(cfg_max_ms) * 64'd1000;
        end else begin
            if (ms == 32'd0) begin
                item_code = ST_ZERO;
            end
            scaled = 64'(ms) * 64'd1000;
        end
        return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    endfunction

    // Active state as it will be once the queued commands have been applied
    function automatic logic run_pending();
        if (tmr_pending[F_STOP]) return 1'b0;
        if (tmr_pending[F_START]) return 1'b1;
        return tmr_active;
    endfunction

    function automatic void reset_timer_model();
        cfg_min_ms       = RST_MIN_TIME_MS;
        cfg_max_ms       = RST_MAX_TIME_MS;
        cfg_budget_us    = RST_MAX_TIME_US;
        cfg_margin_us    = RST_MARGIN_US;
        tmr_active       = 1'b0;
        tmr_req_phase    = PH_STOP;
        tmr_shown_phase  = PH_STOP;
        tmr_changed      = 1'b0;
        tmr_pending      = '0;
        tmr_countdown_us = clamp_countdown(32'd0);
        tmr_elapsed_us   = '0;
        tmr_remaining_us = '0;
        ts_start         = '0;
        ts_stop          = '0;
        ts_paused        = '0;
        ts_pause_begin   = '0;
        item_code        = ST_OK;
    endfunction

    // Apply one accepted transaction to the predicted timer and return the
    // snapshot the block must report for it.
    function automatic t_result predict_snapshot(input t_item it);
        t_result     r;
        logic        live;
        logic [31:0] held;
        logic [31:0] used;
        logic [31:0] room;
        logic [31:0] spent;
        item_code = ST_OK;
        if (it.op == OP_TICK) begin
            tmr_changed = 1'b0;
            tmr_shown_phase = tmr_req_phase;
            // Start or reset: stamp the start, clear the run
            if (tmr_pending[F_START]) begin
                tmr_pending[F_START] = 1'b0;
                if (tmr_countdown_us != 32'd0) begin
                    tmr_pending[F_CALC] = !tmr_pending[F_BPAUSE];
                end else begin
                    tmr_pending[F_CALC] = 1'b0;
                    tmr_pending[F_STOP] = 1'b1;
                end
                tmr_changed      = 1'b1;
                tmr_active       = 1'b1;
                ts_start         = it.now_us;
                tmr_remaining_us = tmr_countdown_us;
                tmr_elapsed_us   = '0;
                ts_paused        = '0;
                ts_pause_begin   = '0;
                ts_stop          = '0;
            end
            if (tmr_pending[F_BPAUSE]) begin
                tmr_pending[F_BPAUSE] = 1'b0;
                tmr_changed = 1'b1;
                ts_pause_begin = it.now_us;
            end
            // Pause budget: both sides wrap before the compare
            if (tmr_active && tmr_shown_phase == PH_PAUSE && !tmr_pending[F_EPAUSE]) begin
                held = it.now_us - ts_pause_begin;
                used = held + ts_paused;
                room = cfg_budget_us - tmr_countdown_us;
                if (used >= room) begin
                    item_code = ST_PAUSE_BUDGET;
                    tmr_pending[F_EPAUSE] = 1'b1;
                    tmr_pending[F_CALC]   = 1'b1;
                    tmr_pending[F_STOP]   = 1'b1;
                end
            end
            if (tmr_pending[F_EPAUSE]) begin
                tmr_pending[F_EPAUSE] = 1'b0;
                tmr_changed = 1'b1;
                ts_paused = (it.now_us - ts_pause_begin) + ts_paused;
            end
            // Elapsed plus margin is compared at full width, no wrap
            if (tmr_pending[F_CALC]) begin
                spent = it.now_us - ts_paused - ts_start;
                if ({32'd0, spent} + {48'd0, cfg_margin_us} >= {32'd0, tmr_countdown_us}) begin
                    tmr_remaining_us = '0;
                    spent = tmr_countdown_us;
                    tmr_pending[F_CALC] = 1'b0;
                    tmr_pending[F_STOP] = 1'b1;
                end else begin
                    tmr_remaining_us = tmr_countdown_us - spent;
                end
                tmr_elapsed_us = spent;
            end
            if (tmr_pending[F_STOP]) begin
                tmr_pending     = '0;
                tmr_changed     = 1'b1;
                tmr_active      = 1'b0;
                tmr_shown_phase = PH_STOP;
                tmr_req_phase   = PH_STOP;
                ts_stop         = it.now_us;
                timer_stops++;
            end
        end else begin
            live = run_pending();
            if (it.command == CMD_SET_CD) begin
                // Set countdown reads the value whatever the flag says
                if (!live) begin
                    tmr_countdown_us = clamp_countdown(it.countdown_ms);
                end else begin
                    item_code = ST_NOT_COMPLETE;
                end
            end else if (it.command > CMD_SET_CD) begin
                item_code = ST_BAD_ARG;
            end else begin
                if (it.with_countdown) begin
                    if (it.command == CMD_RESET || (it.command == CMD_START && !live)) begin
                        tmr_countdown_us = clamp_countdown(it.countdown_ms);
                    end else if (it.command != CMD_START || tmr_req_phase == PH_PAUSE) begin
                        item_code = ST_CD_IGNORED;
                    end
                end
                // Queue the work for the next tick
                case (it.command)
                    CMD_START: begin
                        if (!live) begin
                            tmr_pending[F_START]  = 1'b1;
                            tmr_pending[F_EPAUSE] = 1'b0;
                            tmr_pending[F_STOP]   = 1'b0;
                            tmr_req_phase = PH_START;
                        end else if (tmr_req_phase == PH_PAUSE) begin
                            tmr_pending[F_EPAUSE] = 1'b1;
                            tmr_pending[F_CALC]   = 1'b1;
                            tmr_req_phase = PH_START;
                        end else begin
                            item_code = ST_NOT_COMPLETE;
                        end
                    end
                    CMD_RESET: begin
                        tmr_pending[F_START]  = 1'b1;
                        tmr_pending[F_BPAUSE] = 1'b0;
                        tmr_pending[F_EPAUSE] = 1'b0;
                        tmr_pending[F_STOP]   = 1'b0;
                        tmr_req_phase = PH_RESET;
                    end
                    CMD_PAUSE: begin
                        if (!live) begin
                            item_code = ST_NOT_ACTIVE;
                        end else if (tmr_req_phase == PH_START || tmr_req_phase == PH_RESET) begin
                            tmr_pending[F_BPAUSE] = 1'b1;
                            tmr_pending[F_CALC]   = 1'b0;
                            tmr_req_phase = PH_PAUSE;
                        end else begin
                            item_code = ST_ALREADY_PAUSED;
                        end
                    end
                    default: begin
                        if (!live) begin
                            item_code = ST_NOT_ACTIVE;
                        end else begin
                            tmr_pending[F_STOP] = 1'b1;
                            tmr_pending[F_CALC] = 1'b1;
                            if (tmr_req_phase == PH_PAUSE) begin
                                tmr_pending[F_EPAUSE] = 1'b1;
                            end
                            tmr_req_phase = PH_STOP;
                        end
                    end
                endcase
            end
        end
        r.running       = tmr_active;
        r.phase         = tmr_shown_phase;
        r.phase_changed = tmr_changed;
        r.elapsed_us    = tmr_elapsed_us;
        r.remaining_us  = tmr_remaining_us;
        r.start_us      = ts_start;
        r.stop_us       = ts_stop;
        r.paused_us     = ts_paused;
        r.status        = item_code;
        status_seen[item_code]++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Channel helpers
    // ------------------------------------------------------------------------
    // Idle cycles before the next transaction on either side
    function automatic int unsigned draw_gap();
        return idling_on ? $urandom_range(0, 10) : 0;
    endfunction

    // Offer one transaction; keep valid high across back-to-back transactions.
    // The prediction is taken at the edge that accepts it.
    task automatic send_item(input t_item it);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= it.op;
        i_command        <= it.command;
        i_with_countdown <= it.with_countdown;
        i_countdown_ms   <= it.countdown_ms;
        i_now_us         <= it.now_us;
        do @(posedge i_clk); while (!o_in_ready);
        expected_snapshots.push_back(predict_snapshot(it));
        items_sent++;
        if (it.op == OP_TICK) begin
            ticks_sent++;
        end
    endtask

    task automatic issue_command(input logic [2:0] cmd, input logic with_cd,
                                 input logic [31:0] ms);
        t_item it;
        it.op             = OP_COMMAND;
        it.command        = cmd;
        it.with_countdown = with_cd;
        it.countdown_ms   = ms;
        it.now_us         = $urandom;
        send_item(it);
    endtask

    task automatic issue_tick(input logic [31:0] stamp);
        t_item it;
        it.op             = OP_TICK;
        it.command        = 3'($urandom);
        it.with_countdown = 1'($urandom);
        it.countdown_ms   = $urandom;
        it.now_us         = stamp;
        send_item(it);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe drain
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (expected_snapshots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write per cycle; the caller lowers the write enable
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_TIME_MS: cfg_min_ms    = data[15:0];
            CFG_MAX_TIME_MS: cfg_max_ms    = data[22:0];
            CFG_MAX_TIME_US: cfg_budget_us = data;
            CFG_MARGIN_US:   cfg_margin_us = data[15:0];
            CFG_INIT_CD_MS:  tmr_countdown_us = clamp_countdown({9'd0, data[22:0]});
            default: ;
        endcase
        config_writes++;
    endtask

    // Write all registers while idle; the initial countdown goes last so that
    // it is clamped against the new limits.
    task automatic load_config(input logic [15:0] min_ms, input logic [22:0] max_ms,
                               input logic [31:0] budget_us, input logic [15:0] margin,
                               input logic [22:0] init_ms);
        settle_pipeline();
        write_register(CFG_MIN_TIME_MS, {16'd0, min_ms});
        write_register(CFG_MAX_TIME_MS, {9'd0, max_ms});
        write_register(CFG_MAX_TIME_US, budget_us);
        write_register(CFG_MARGIN_US, {16'd0, margin});
        write_register(CFG_INIT_CD_MS, {9'd0, init_ms});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_extreme(input logic [31:0] lo, input logic [31:0] hi,
                                                 input logic [31:0] typical);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return typical;
        endcase
    endfunction

    // Random transaction: mostly ticks on an advancing clock and well-formed
    // timer commands, with junk in the fields each kind ignores.
    task automatic send_random_item();
        t_item       it;
        int unsigned pick;
        pick              = $urandom_range(0, 99);
        it.op             = OP_COMMAND;
        it.command        = 3'($urandom);
        it.with_countdown = ($urandom_range(0, 9) < 3);
        it.now_us         = $urandom;
        case ($urandom_range(0, 9))
            0: it.countdown_ms = $urandom;
            1: it.countdown_ms = '0;
            2: it.countdown_ms = {16'd0, cfg_min_ms} - 32'd1 + $urandom_range(0, 2);
            3: it.countdown_ms = {9'd0, cfg_max_ms} - 32'd1 + $urandom_range(0, 2);
            default: it.countdown_ms = $urandom_range(1, 30);
        endcase
        if (pick < 55) begin
            // Advance the wall clock, now and then jumping or wrapping
            case ($urandom_range(0, 19))
                0: wall_us = $urandom;
                1, 2: wall_us += $urandom_range(0, 65535);
                default: wall_us += $urandom_range(0, 3000);
            endcase
            it.op = OP_TICK;
            it.now_us = wall_us;
        end else if (pick < 66) begin
            it.command = CMD_PAUSE;
        end else if (pick < 77) begin
            it.command = CMD_START;
        end else if (pick < 83) begin
            it.command = CMD_STOP;
        end else if (pick < 90) begin
            it.command = CMD_RESET;
        end else if (pick < 95) begin
            it.command = CMD_SET_CD;
        end
        send_item(it);
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: draw a stall per result, honor a hold-off request, and
    // check every accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        end
    endfunction

    initial begin : result_monitor
        int unsigned stall_left;
        logic        next_ready;
        t_result     want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid) begin
                if (expected_snapshots.size() == 0) begin
                    mismatch_count++;
                    $error("result transaction with no prediction outstanding");
                end else begin
                    want = expected_snapshots.pop_front();
                    compare_field("running", want.running, o_running);
                    compare_field("phase", want.phase, o_phase);
                    compare_field("phase_changed", want.phase_changed, o_phase_changed);
                    compare_field("elapsed_us", want.elapsed_us, o_elapsed_us);
                    compare_field("remaining_us", want.remaining_us, o_remaining_us);
                    compare_field("start_us", want.start_us, o_start_us);
                    compare_field("stop_us", want.stop_us, o_stop_us);
                    compare_field("paused_us", want.paused_us, o_paused_us);
                    compare_field("status", want.status, o_status);
                    results_checked++;
                end
                stall_left = draw_gap();
            end
            // A hold-off request overrides the drawn stall
            if (hold_request != 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                next_ready = 1'b0;
                stall_left--;
            end else begin
                next_ready = 1'b1;
            end
            i_out_ready <= next_ready;
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_snapshots.size());
            $display("pausable_countdown_timer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset-value registers: status codes, command queueing and wrapping ticks
    task automatic test_command_queue();
        issue_tick(32'd0);                              // nothing queued yet
        issue_command(CMD_UNUSED_FIRST, 1'b0, '0);      // bad argument
        issue_command(CMD_STOP, 1'b0, '0);              // stop while complete
        issue_command(CMD_PAUSE, 1'b1, 32'd25);         // ignored value, then not active
        issue_command(CMD_START, 1'b0, '0);
        issue_tick(32'd100);                            // zero countdown stops at once
        issue_command(CMD_SET_CD, 1'b1, 32'd0);         // zero request
        issue_command(CMD_SET_CD, 1'b0, 32'd5);         // flag ignored, raised to min
        issue_command(CMD_START, 1'b1, 32'hFFFF_FFFF);  // clamped to max
        issue_command(CMD_SET_CD, 1'b1, 32'd12);        // start is queued: refused
        issue_command(CMD_RESET, 1'b1, 32'd20);         // reset reloads the countdown
        issue_tick(32'hFFFF_FF00);
        issue_command(CMD_PAUSE, 1'b0, '0);
        issue_command(CMD_PAUSE, 1'b0, '0);             // already paused
        issue_tick(32'hFFFF_FF00 + 32'd3000);           // pause begins across the wrap
        issue_command(CMD_START, 1'b1, 32'd7);          // resume; value ignored
        issue_tick(32'hFFFF_FF00 + 32'd8000);
        issue_command(CMD_START, 1'b0, '0);             // running: not complete
        issue_command(CMD_STOP, 1'b1, 32'd9);           // value ignored, stop queued
        issue_tick(32'hFFFF_FF00 + 32'd9000);
        issue_command(CMD_UNUSED_LAST, 1'b1, '0);
    endtask

    // Limit extremes: min above max, widest countdown and margin
    task automatic test_clamp_and_margin();
        load_config(16'hFFFF, 23'd1, RST_MAX_TIME_US, RST_MARGIN_US, 23'd0);
        issue_command(CMD_SET_CD, 1'b0, 32'd3);         // below min wins over above max
        issue_command(CMD_SET_CD, 1'b0, 32'd70000);     // above both: held to max
        load_config(16'd0, 23'd4294967, 32'hFFFF_FFFF, 16'hFFFF, 23'd4294967);
        issue_command(CMD_RESET, 1'b0, '0);
        issue_tick(32'd5);
        // Elapsed plus margin passes 2^32 here and must still finish the run
        issue_tick(32'd5 + 32'd4294966900);
    endtask

    // Pause budget: a tight budget forces a stop; a budget below the
    // countdown wraps to a huge allowance and never trips.
    task automatic test_pause_budget();
        load_config(RST_MIN_TIME_MS, RST_MAX_TIME_MS, 32'd23000, 16'd0, 23'd20);
        issue_command(CMD_RESET, 1'b0, '0);
        issue_tick(32'd1000);
        issue_command(CMD_PAUSE, 1'b0, '0);
        issue_tick(32'd1500);
        issue_tick(32'd4600);                           // 3100 us paused, 3000 allowed
        load_config(RST_MIN_TIME_MS, RST_MAX_TIME_MS, 32'd1, RST_MARGIN_US, 23'd20);
        issue_command(CMD_RESET, 1'b1, 32'd20);
        issue_command(CMD_PAUSE, 1'b0, '0);
        issue_tick(32'd10000);
        issue_tick(32'd900000);
    endtask

    // Hold the result channel off while the sender keeps offering, so the
    // block fills and drops its input ready.
    task automatic test_result_backpressure();
        int i;
        settle_pipeline();
        idling_on = 1'b0;
        hold_request = HOLD_OFF_LEN;
        for (i = 0; i < 48; i++) begin
            send_random_item();
        end
        idling_on = 1'b1;
    endtask

    // Random sessions under changing register settings; every third phase
    // runs with no idling on either side.
    task automatic test_random_sessions();
        int unsigned phase_num;
        int unsigned n;
        wall_us = $urandom;
        for (phase_num = 0; phase_num < RANDOM_PHASES; phase_num++) begin
            load_config(16'(pick_extreme(32'd0, 32'd65535, $urandom_range(0, 20))),
                        23'(pick_extreme(32'd1, 32'd4294967, $urandom_range(10, 100))),
                        pick_extreme(32'd1, 32'hFFFF_FFFF, $urandom_range(20000, 200000)),
                        16'(pick_extreme(32'd0, 32'd65535, $urandom_range(0, 2000))),
                        23'(pick_extreme(32'd0, 32'd4294967, $urandom_range(0, 40))));
            idling_on = (phase_num % 3 != 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
            end
        end
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests, drain, report
    // ------------------------------------------------------------------------
    initial begin
        reset_timer_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_command_queue();
        test_clamp_and_margin();
        test_pause_budget();
        test_result_backpressure();
        test_random_sessions();

        settle_pipeline();
        $display("covered %0d transactions (%0d ticks), %0d register writes, %0d results checked",
                 items_sent, ticks_sent, config_writes, results_checked);
        $display("timer stops %0d, pause-budget stops %0d, clamped countdowns %0d",
                 timer_stops, status_seen[ST_PAUSE_BUDGET],
                 status_seen[ST_BELOW_MIN] + status_seen[ST_ABOVE_MAX]);
        if (mismatch_count == 0 && expected_snapshots.size() == 0) begin
            $display("pausable_countdown_timer regression: pass");
        end else begin
            $display("pausable_countdown_timer regression: fail");
        end
        $finish;
    end

endmodule

// ===== pausable_countdown_timer.f =====
rtl/core/pct_pkg.sv
rtl/core/pct_in_stage.sv
rtl/core/pct_core.sv
rtl/core/pct_out_stage.sv
rtl/core/pausable_countdown_timer.sv
verif/testbench.sv
